// File: src/dds_pkg.sv
// Shared constants, register codes and the arctangent table of the sine generator.
package dds_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SINE_ITER_DEF   = 20;

   localparam int POS_W      = 15;
   localparam int OFFSET_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int TURN_W     = 32;
   localparam int CORDIC_W   = 34;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_OFFSET = 2'd3;

   localparam logic [POS_W-1:0]    TABLE_SIZE_RST   = 15'd4800;
   localparam logic [POS_W-1:0]    PHASE_STEP_RST   = 15'd100;
   localparam logic [POS_W-1:0]    AMPLITUDE_RST    = 15'd16384;
   localparam logic [OFFSET_W-1:0] PHASE_OFFSET_RST = 16'd0;

   localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic [30:0]                HALF_PI_Q30 = 31'd1686629713;

   typedef logic signed [CORDIC_W-1:0] cordic_word_type;

   function automatic cordic_word_type atan_q30(input logic [5:0] idx);
      cordic_word_type a;
      case (idx)
         6'd0:  a = 34'sh03243F6A8;
         6'd1:  a = 34'sh01DAC6705;
         6'd2:  a = 34'sh00FADBAFC;
         6'd3:  a = 34'sh007F56EA6;
         6'd4:  a = 34'sh003FEAB76;
         6'd5:  a = 34'sh001FFD55B;
         6'd6:  a = 34'sh000FFFAAA;
         6'd7:  a = 34'sh0007FFF55;
         6'd8:  a = 34'sh0003FFFEA;
         6'd9:  a = 34'sh0001FFFFD;
         6'd10: a = 34'sh0000FFFFF;
         6'd11: a = 34'sh00007FFFF;
         6'd12: a = 34'sh00003FFFF;
         6'd13: a = 34'sh00001FFFF;
         6'd14: a = 34'sh00000FFFF;
         6'd15: a = 34'sh000007FFF;
         6'd16: a = 34'sh000003FFF;
         6'd17: a = 34'sh000001FFF;
         6'd18: a = 34'sh000000FFF;
         6'd19: a = 34'sh0000007FF;
         6'd20: a = 34'sh0000003FF;
         6'd21: a = 34'sh0000001FF;
         6'd22: a = 34'sh0000000FF;
         6'd23: a = 34'sh00000007F;
         6'd24: a = 34'sh00000003F;
         6'd25: a = 34'sh00000001F;
         6'd26: a = 34'sh00000000F;
         6'd27: a = 34'sh000000008;
         6'd28: a = 34'sh000000004;
         6'd29: a = 34'sh000000002;
         6'd30: a = 34'sh000000001;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// File: src/dds_req_if.sv
// Request channel: one tick word per sample.
interface dds_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

// File: src/dds_rsp_if.sv
// Response channel: one sample word with the position it was taken at.
interface dds_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic [14:0]                   position;

   modport source (output valid, output sample, output position, input ready);
   modport sink   (input valid, input sample, input position, output ready);
endinterface

// File: src/dds_cordic.sv
// Iterative CORDIC rotation, one micro-rotation per cycle.
module dds_cordic
   import dds_pkg::*;
#(
   parameter int SINE_ITERATIONS = SINE_ITER_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  cordic_word_type z_init,
   output cordic_word_type x_out,
   output cordic_word_type y_out,
   output logic            done
);
   localparam int CNT_W = $clog2(SINE_ITERATIONS + 1);

   cordic_word_type  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   cordic_word_type  dx, dy, ang;

   always_comb begin
      dx  = y_ff >>> cnt_ff;
      dy  = x_ff >>> cnt_ff;
      ang = atan_q30(6'(cnt_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = GAIN_Q30;
         y_in    = '0;
         z_in    = z_init;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SINE_ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign done  = done_ff;
endmodule

// File: src/dds_sine_generator.sv
// DDS sine generator top level: registers, phase sequencer, scaling and output stage.
// Each accepted tick word with tick high yields one sample word; a tick of zero is
// dropped. After its tick is accepted, the sample word passes through a bit-serial
// modulo of position and step, a bit-serial 32-bit turn division by table_size, the
// angle state, the CORDIC start, one micro-rotation per cycle and its done pulse, then
// product, scaling and output load. The next tick can be taken in the cycle after the
// output load; the output load waits while an earlier word is still held in the
// output register. One word is in flight at a time; a finished sample waits in the
// output register while the next tick is taken.
module dds_sine_generator
   import dds_pkg::*;
#(
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
   parameter int SINE_ITERATIONS = SINE_ITER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   dds_req_if.sink               req_chan,
   dds_rsp_if.source             rsp_chan
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MOD    = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_ZMUL   = 3'd3;
   localparam logic [2:0] S_CORDIC = 3'd4;
   localparam logic [2:0] S_PROD   = 3'd5;
   localparam logic [2:0] S_SCALE  = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   localparam logic signed [33:0] MAX_V = 34'sd1 <<< (SAMPLE_BITS - 1);
   localparam logic signed [33:0] MAXV  = MAX_V - 34'sd1;
   localparam logic signed [33:0] MINV  = -MAX_V;

   logic [POS_W-1:0]    table_size_ff, phase_step_ff, amplitude_ff;
   logic [OFFSET_W-1:0] phase_offset_ff;
   logic [POS_W-1:0]    phase_position_ff, phase_position_in;

   logic [2:0]          state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [POS_W-1:0]    ts_ff, ts_in;
   logic [POS_W-1:0]    a_sh_ff, a_sh_in, b_sh_ff, b_sh_in;
   logic [POS_W-1:0]    rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [POS_W-1:0]    div_rem_ff, div_rem_in;
   logic [TURN_W-1:0]   quo_ff, quo_in;
   logic [1:0]          quad_ff, quad_in;
   cordic_word_type     z0_ff, z0_in;
   logic signed [49:0]  prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0] res_ff, res_in;
   logic                cordic_start;
   cordic_word_type     cx, cy, s_sel;
   logic                cordic_done;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;

   logic [15:0]         ra_sh, rb_sh, dr_sh;
   logic                ra_ge, rb_ge, dr_ge;
   logic [TURN_W-1:0]   turn;
   logic [60:0]         zprod;
   logic [49:0]         mag;
   logic [7:0]          fr;
   logic [19:0]         ip;
   logic [19:0]         ip_r;
   logic signed [33:0]  val;
   logic [15:0]         next_sum;
   logic                out_load;

   dds_cordic #(.SINE_ITERATIONS(SINE_ITERATIONS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .z_init (z0_ff),
      .x_out  (cx),
      .y_out  (cy),
      .done   (cordic_done)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff   <= TABLE_SIZE_RST;
         phase_step_ff   <= PHASE_STEP_RST;
         amplitude_ff    <= AMPLITUDE_RST;
         phase_offset_ff <= PHASE_OFFSET_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TABLE_SIZE:   table_size_ff   <= csr_data[POS_W-1:0];
            CSR_PHASE_STEP:   phase_step_ff   <= csr_data[POS_W-1:0];
            CSR_AMPLITUDE:    amplitude_ff    <= csr_data[POS_W-1:0];
            CSR_PHASE_OFFSET: phase_offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      // restoring remainder steps, one dividend bit per cycle
      ra_sh = {rem_a_ff, a_sh_ff[POS_W-1]};
      rb_sh = {rem_b_ff, b_sh_ff[POS_W-1]};
      dr_sh = {div_rem_ff, 1'b0};
      ra_ge = ra_sh >= {1'b0, ts_ff};
      rb_ge = rb_sh >= {1'b0, ts_ff};
      dr_ge = dr_sh >= {1'b0, ts_ff};

      turn  = quo_ff + {phase_offset_ff, 16'd0};
      zprod = {1'b0, turn[29:0]} * {30'd0, HALF_PI_Q30};

      case (quad_ff)
         2'd0:    s_sel = cy;
         2'd1:    s_sel = cx;
         2'd2:    s_sel = -cy;
         default: s_sel = -cx;
      endcase

      mag  = prod_ff[49] ? 50'(-prod_ff) : 50'(prod_ff);
      fr   = mag[29:22];
      ip   = mag[49:30];
      ip_r = (({4'd0, fr} * 12'd10) > 12'd768) ? ip + 20'd1 : ip;
      val  = prod_ff[49] ? -$signed({14'd0, ip_r}) : $signed({14'd0, ip_r});
      if (val > MAXV)      res_in = MAXV[SAMPLE_BITS-1:0];
      else if (val < MINV) res_in = MINV[SAMPLE_BITS-1:0];
      else                 res_in = val[SAMPLE_BITS-1:0];

      next_sum = {1'b0, rem_a_ff} + {1'b0, rem_b_ff};
      out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

      state_in          = state_ff;
      cnt_in            = cnt_ff;
      ts_in             = ts_ff;
      a_sh_in           = a_sh_ff;
      b_sh_in           = b_sh_ff;
      rem_a_in          = rem_a_ff;
      rem_b_in          = rem_b_ff;
      div_rem_in        = div_rem_ff;
      quo_in            = quo_ff;
      quad_in           = quad_ff;
      z0_in             = z0_ff;
      prod_in           = prod_ff;
      cordic_start      = 1'b0;
      phase_position_in = phase_position_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_sample_in     = rsp_sample_ff;
      rsp_pos_in        = rsp_pos_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid && req_chan.tick) begin
               ts_in    = (table_size_ff == '0) ? POS_W'(1) : table_size_ff;
               a_sh_in  = phase_position_ff;
               b_sh_in  = phase_step_ff;
               rem_a_in = '0;
               rem_b_in = '0;
               cnt_in   = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            rem_a_in = ra_ge ? POS_W'(ra_sh - {1'b0, ts_ff}) : ra_sh[POS_W-1:0];
            rem_b_in = rb_ge ? POS_W'(rb_sh - {1'b0, ts_ff}) : rb_sh[POS_W-1:0];
            a_sh_in  = {a_sh_ff[POS_W-2:0], 1'b0};
            b_sh_in  = {b_sh_ff[POS_W-2:0], 1'b0};
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff == 6'(POS_W - 1)) begin
               div_rem_in = rem_a_in;
               quo_in     = '0;
               cnt_in     = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            div_rem_in = dr_ge ? POS_W'(dr_sh - {1'b0, ts_ff}) : dr_sh[POS_W-1:0];
            quo_in     = {quo_ff[TURN_W-2:0], dr_ge};
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff == 6'(TURN_W - 1)) state_in = S_ZMUL;
         end
         S_ZMUL: begin
            quad_in  = turn[31:30];
            z0_in    = CORDIC_W'(zprod[60:30]);
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            // start pulse on entry; z0 is already registered
            cordic_start = (cnt_ff != 6'd0);
            cnt_in       = '0;
            if (cordic_done) state_in = S_PROD;
         end
         S_PROD: begin
            prod_in  = $signed({1'b0, amplitude_ff}) * s_sel;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in      = 1'b1;
               rsp_sample_in     = res_ff;
               rsp_pos_in        = rem_a_ff;
               phase_position_in = (next_sum >= {1'b0, ts_ff}) ?
                                   POS_W'(next_sum - {1'b0, ts_ff}) : next_sum[POS_W-1:0];
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         cnt_ff            <= '0;
         phase_position_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         cnt_ff            <= cnt_in;
         phase_position_ff <= phase_position_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      ts_ff         <= ts_in;
      a_sh_ff       <= a_sh_in;
      b_sh_ff       <= b_sh_in;
      rem_a_ff      <= rem_a_in;
      rem_b_ff      <= rem_b_in;
      div_rem_ff    <= div_rem_in;
      quo_ff        <= quo_in;
      quad_ff       <= quad_in;
      z0_ff         <= z0_in;
      prod_ff       <= prod_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_pos_ff    <= rsp_pos_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.sample   = rsp_sample_ff;
   assign rsp_chan.position = rsp_pos_ff;

   a_next_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      out_load |=> phase_position_ff < ts_ff)
      else $error("next position not below table size");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_rem_ff < ts_ff)
      else $error("turn division remainder out of range");

   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == S_CORDIC)
      else $error("CORDIC finished outside its phase");

   a_out_pos: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_chan.valid && rsp_chan.position == $past(rem_a_ff))
      else $error("response word lost its position");
endmodule

// File: tb/dds_sine_generator_tb.sv
// Self-checking testbench of the DDS sine generator: directed table, then random ticks.
module testbench
   import dds_pkg::*;
();

   localparam int SB = SAMPLE_BITS_DEF;
   localparam int NITER = SINE_ITER_DEF;
   localparam int N_RANDOM = 1750;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct {
      logic signed [SB-1:0] sample;
      logic [POS_W-1:0]     position;
   } sample_word_type;

   typedef struct {
      logic                  do_write;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic                  tick;
      logic                  known;
      logic signed [SB-1:0]  sample;
      logic [POS_W-1:0]      position;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   dds_req_if req_chan ();
   dds_rsp_if #(.SAMPLE_BITS(SB)) rsp_chan ();

   dds_sine_generator #(.SAMPLE_BITS(SB), .SINE_ITERATIONS(NITER)) uut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [POS_W-1:0]    m_table_size, m_phase_step, m_amplitude, m_position;
   logic [OFFSET_W-1:0] m_phase_offset;

   sample_word_type expected_samples[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint sine_of_turn(logic [31:0] turn);
      longint x, y, z, dx, dy;
      logic [1:0] quad;
      logic [63:0] frac;
      x = GAIN_Q30;
      y = 0;
      quad = turn[31:30];
      frac = {34'd0, turn[29:0]};
      z = longint'((frac * 64'(HALF_PI_Q30)) >> 30);
      for (int i = 0; i < NITER; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_q30(6'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(atan_q30(6'(i)));
         end
      end
      case (quad)
         2'd0: return y;
         2'd1: return x;
         2'd2: return -y;
         default: return -x;
      endcase
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_TABLE_SIZE:   m_table_size = d[POS_W-1:0];
         CSR_PHASE_STEP:   m_phase_step = d[POS_W-1:0];
         CSR_AMPLITUDE:    m_amplitude = d[POS_W-1:0];
         CSR_PHASE_OFFSET: m_phase_offset = d;
         default: ;
      endcase
   endfunction

   function automatic sample_word_type next_sample();
      sample_word_type w;
      longint unsigned ts, pos, stp, nxt, mag, q8, ip, fr;
      longint s, prod, val;
      logic [31:0] turn;
      logic [63:0] num;
      ts = (m_table_size == 0) ? 1 : m_table_size;
      pos = m_position % ts;
      num = 64'(pos) << 32;
      turn = 32'(num / ts + (64'(m_phase_offset) << 16));
      s = sine_of_turn(turn);
      prod = longint'(m_amplitude) * s;
      mag = (prod < 0) ? -prod : prod;
      q8 = mag >> 22;
      ip = q8 >> 8;
      fr = q8 & 255;
      if (fr * 10 > 3 * 256) ip++;
      val = (prod < 0) ? -longint'(ip) : longint'(ip);
      if (val > (2 ** (SB - 1)) - 1) val = (2 ** (SB - 1)) - 1;
      if (val < -(2 ** (SB - 1))) val = -(2 ** (SB - 1));
      w.sample = SB'(val);
      w.position = POS_W'(pos);
      stp = m_phase_step % ts;
      nxt = pos + stp;
      if (nxt >= ts) nxt -= ts;
      m_position = POS_W'(nxt);
      return w;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      error_count++;
   endtask

   // response side: stall, sample and compare at the rising edge
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      sample_word_type w;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_samples.size() == 0) begin
            $display("unexpected sample word %0d at cycle %0d", rsp_chan.sample, cycle_count);
            error_count++;
         end else begin
            w = expected_samples.pop_front();
            if (rsp_chan.sample !== w.sample) report("sample", rsp_chan.sample, w.sample);
            if (rsp_chan.position !== w.position) report("position", rsp_chan.position, w.position);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // drops the request and waits until every word has come back
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (expected_samples.size() != 0) @(negedge clock);
   endtask

   task automatic wait_drained();
      hold_until_drained();
      repeat (100) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(negedge clock);
      csr_write <= 1'b0;
      apply_register(idx, d);
      @(negedge clock);
   endtask

   // drives one tick word; a tick-high word books its expectation on acceptance
   task automatic send_tick(logic t, logic known, logic signed [SB-1:0] ks, logic [POS_W-1:0] kp);
      sample_word_type w;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.tick <= t;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (t) begin
         w = next_sample();
         if (known && (w.sample !== ks || w.position !== kp))
            $display("note: table row disagrees with predictor");
         if (known) begin
            w.sample = ks;
            w.position = kp;
         end
         expected_samples.push_back(w);
      end
      @(negedge clock);
   endtask

   task automatic random_settings(int mode);
      logic [POS_W-1:0] ts;
      case (mode)
         0: ts = 15'd1;
         1: ts = 15'd19200;
         default: ts = POS_W'($urandom_range(19200, 1));
      endcase
      if ($urandom_range(9) == 0) ts = 15'd0;
      write_register(CSR_TABLE_SIZE, 16'(ts));
      write_register(CSR_PHASE_STEP, 16'($urandom_range(32767)));
      write_register(CSR_AMPLITUDE, (mode == 1) ? 16'd32767 : 16'($urandom_range(32767)));
      write_register(CSR_PHASE_OFFSET, (mode == 0) ? 16'hFFFF : 16'($urandom));
      write_register(CSR_TABLE_SIZE, 16'(ts) | 16'h8000); // top bit is dropped
   endtask

   vector_type directed[20] = '{
      // after reset: position 0, sine 0
      '{1'b0, CSR_TABLE_SIZE, 16'd0, 1'b1, 1'b1, 16'sd0, 15'd0},
      // second tick at 4800/100: position 100
      '{1'b0, CSR_TABLE_SIZE, 16'd0, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b0, CSR_TABLE_SIZE, 16'd0, 1'b0, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_AMPLITUDE, 16'd32767, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_PHASE_OFFSET, 16'h4000, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_PHASE_STEP, 16'd1200, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b0, CSR_TABLE_SIZE, 16'd0, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_PHASE_OFFSET, 16'hFFFF, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_TABLE_SIZE, 16'd0, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_TABLE_SIZE, 16'd19200, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_PHASE_STEP, 16'd32767, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_PHASE_STEP, 16'd19199, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_TABLE_SIZE, 16'd7, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b0, CSR_TABLE_SIZE, 16'd0, 1'b0, 1'b0, 16'sd0, 15'd0},
      // zero amplitude in a table of 7: sample 0 at position 1
      '{1'b1, CSR_AMPLITUDE, 16'd0, 1'b1, 1'b1, 16'sd0, 15'd1},
      '{1'b1, CSR_PHASE_OFFSET, 16'h0000, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_AMPLITUDE, 16'd1, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_TABLE_SIZE, 16'd1, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_AMPLITUDE, 16'hFFFF, 1'b1, 1'b0, 16'sd0, 15'd0},
      '{1'b1, CSR_PHASE_STEP, 16'd0, 1'b1, 1'b0, 16'sd0, 15'd0}
   };

   initial begin
      int phase;
      req_chan.valid = 1'b0;
      req_chan.tick = 1'b0;
      m_table_size = TABLE_SIZE_RST;
      m_phase_step = PHASE_STEP_RST;
      m_amplitude = AMPLITUDE_RST;
      m_phase_offset = PHASE_OFFSET_RST;
      m_position = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         // register writes only while nothing is in flight
         if (directed[i].do_write) begin
            wait_drained();
            write_register(directed[i].index, directed[i].data);
         end
         send_tick(directed[i].tick, directed[i].known, directed[i].sample,
                   directed[i].position);
      end
      wait_drained();

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 100 == 0) begin
            phase = (n / 100) % 4;
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 11 : 51) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 11 : 51) : 0;
            wait_drained();
            random_settings(n / 100);
         end
         // hold off until everything has come back
         if (n % 37 == 0) hold_until_drained();
         send_tick($urandom_range(9) != 0, 1'b0, '0, '0);
      end

      hold_until_drained();
      repeat (200) @(negedge clock);
      if (error_count == 0 && expected_samples.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// File: dds_sine_generator.f
src/dds_pkg.sv
src/dds_req_if.sv
src/dds_rsp_if.sv
src/dds_cordic.sv
src/dds_sine_generator.sv
tb/dds_sine_generator_tb.sv
